### sv/dzep_pkg.sv
// ---------------------------------------------------------------------------
// dzep_pkg
// Shared types and constants for the digitizer event parser.
// ---------------------------------------------------------------------------
package dzep_pkg;

  localparam int NUM_CHANNELS = 8;
  localparam int CH_W         = 3;
  localparam int Q_DEPTH      = 4;
  localparam int Q_AW         = $clog2(Q_DEPTH);
  localparam int Q_CW         = $clog2(Q_DEPTH + 1);

  localparam logic [11:0] HDR_TAG    = 12'hA00;
  localparam logic [3:0]  GOOD_TAG   = 4'h8;
  localparam logic [31:0] SKIP_ALL1  = 32'hFFFF_FFFF;
  localparam logic [27:0] RAW_HDR_WC = 28'd4;

  typedef enum logic [1:0] {
    KIND_SAMPLE     = 2'd0,
    KIND_EVENT_END  = 2'd1,
    KIND_BAD_HEADER = 2'd2,
    KIND_BAD_SKIP   = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    PH_HEADER  = 3'd0,
    PH_MASK    = 3'd1,
    PH_SKIPHDR = 3'd2,
    PH_ZSIZE   = 3'd3,
    PH_ZCTRL   = 3'd4,
    PH_ZGOOD   = 3'd5,
    PH_RAW     = 3'd6
  } phase_t;

  // one queued job: an optional sample pair followed by an optional mark
  typedef struct packed {
    logic            has_pair;
    logic            has_extra;
    kind_t           extra_kind;
    logic [CH_W-1:0] chan;
    logic [31:0]     data;
    logic [31:0]     tbase;
  } task_t;

endpackage

### sv/dzep_front.sv
// ---------------------------------------------------------------------------
// dzep_front
// Word parser: walks the block one word per cycle unless q_full; queues jobs.
// ---------------------------------------------------------------------------
module dzep_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            s_tvalid,
  output logic            s_tready,
  input  logic [31:0]     s_tdata,
  input  logic            zs_on,
  input  logic            q_full,
  output logic            push,
  output dzep_pkg::task_t push_task
);

  dzep_pkg::phase_t phase, phase_next;
  logic [1:0]                  hdr_left, hdr_left_next;
  logic [dzep_pkg::NUM_CHANNELS-1:0] mask, mask_next;
  logic [dzep_pkg::CH_W-1:0]   cur_ch, cur_ch_next;
  logic [27:0]                 ewc, ewc_next;
  logic [31:0]                 budget, budget_next;
  logic [31:0]                 counted, counted_next;
  logic [27:0]                 good_left, good_left_next;
  logic [31:0]                 time_counter, time_counter_next;

  logic                        accept;
  logic [dzep_pkg::CH_W:0]     search_from;
  logic                        found;
  logic [dzep_pkg::CH_W-1:0]   found_ch;
  logic [31:0]                 raw_budget;
  logic                        chan_ok;
  logic                        ended, emit_pair, emit_extra;
  dzep_pkg::kind_t             extra_kind;

  assign s_tready = !q_full;
  assign accept   = s_tvalid && !q_full;

  // next enabled channel at or above the search start
  assign search_from = (phase == dzep_pkg::PH_SKIPHDR) ? '0 : ({1'b0, cur_ch} + 1'b1);

  always_comb begin
    found    = 1'b0;
    found_ch = '0;
    for (int c = dzep_pkg::NUM_CHANNELS - 1; c >= 0; c--) begin
      if (mask[c] && ((dzep_pkg::CH_W+1)'(c) >= search_from)) begin
        found    = 1'b1;
        found_ch = dzep_pkg::CH_W'(c);
      end
    end
  end

  assign raw_budget = (ewc >= dzep_pkg::RAW_HDR_WC) ?
                      {7'd0, 25'((ewc - dzep_pkg::RAW_HDR_WC) >> 3)} : '0;
  assign chan_ok    = found && (zs_on || (raw_budget != '0));

  // next state and register values
  always_comb begin
    phase_next        = phase;
    hdr_left_next     = hdr_left;
    mask_next         = mask;
    cur_ch_next       = cur_ch;
    ewc_next          = ewc;
    budget_next       = budget;
    counted_next      = counted;
    good_left_next    = good_left;
    time_counter_next = time_counter;
    ended             = 1'b0;
    emit_pair         = 1'b0;
    emit_extra        = 1'b0;
    extra_kind        = dzep_pkg::KIND_BAD_HEADER;
    begin : decode
      logic go_start;
      logic go_cont;
      go_start = 1'b0;
      go_cont  = 1'b0;
      case (phase)
        dzep_pkg::PH_HEADER: begin
          if (s_tdata[31:20] == dzep_pkg::HDR_TAG) begin
            ewc_next   = s_tdata[27:0];
            phase_next = dzep_pkg::PH_MASK;
          end else begin
            emit_extra = 1'b1;
            extra_kind = dzep_pkg::KIND_BAD_HEADER;
          end
        end
        dzep_pkg::PH_MASK: begin
          mask_next     = s_tdata[dzep_pkg::NUM_CHANNELS-1:0];
          hdr_left_next = 2'd2;
          phase_next    = dzep_pkg::PH_SKIPHDR;
        end
        dzep_pkg::PH_SKIPHDR: begin
          hdr_left_next = hdr_left - 2'd1;
          go_start      = (hdr_left == 2'd1);
        end
        dzep_pkg::PH_ZSIZE: begin
          budget_next  = s_tdata;
          counted_next = 32'd2;
          go_cont      = 1'b1;
        end
        dzep_pkg::PH_ZCTRL: begin
          if (s_tdata[31:28] == dzep_pkg::GOOD_TAG) begin
            good_left_next = s_tdata[27:0];
            counted_next   = counted + 32'd1;
            if (s_tdata[27:0] == '0) begin
              go_cont = 1'b1;
            end else begin
              phase_next = dzep_pkg::PH_ZGOOD;
            end
          end else if (s_tdata == dzep_pkg::SKIP_ALL1) begin
            emit_extra = 1'b1;
            extra_kind = dzep_pkg::KIND_BAD_SKIP;
            phase_next = dzep_pkg::PH_HEADER;
          end else begin
            time_counter_next = time_counter + {s_tdata[30:0], 1'b1};
            counted_next      = counted + 32'd1;
            go_cont           = 1'b1;
          end
        end
        dzep_pkg::PH_ZGOOD: begin
          emit_pair         = 1'b1;
          time_counter_next = time_counter + 32'd2;
          counted_next      = counted + 32'd1;
          good_left_next    = good_left - 28'd1;
          go_cont           = (good_left == 28'd1);
        end
        dzep_pkg::PH_RAW: begin
          emit_pair         = 1'b1;
          time_counter_next = time_counter + 32'd2;
          counted_next      = counted + 32'd1;
          go_start          = ((counted + 32'd1) >= budget);
        end
        default: begin
          phase_next = dzep_pkg::PH_HEADER;
        end
      endcase
      // more control words in this channel, or move to the next one
      if (go_cont) begin
        if (counted_next <= budget_next) begin
          phase_next = dzep_pkg::PH_ZCTRL;
        end else begin
          go_start = 1'b1;
        end
      end
      if (go_start) begin
        if (chan_ok) begin
          cur_ch_next       = found_ch;
          time_counter_next = '0;
          if (zs_on) begin
            phase_next = dzep_pkg::PH_ZSIZE;
          end else begin
            budget_next  = raw_budget;
            counted_next = '0;
            phase_next   = dzep_pkg::PH_RAW;
          end
        end else begin
          phase_next = dzep_pkg::PH_HEADER;
          ended      = 1'b1;
        end
      end
    end
  end

  // job handed to the back end
  always_comb begin
    push                 = accept && (emit_pair || emit_extra || ended);
    push_task.has_pair   = emit_pair;
    push_task.has_extra  = emit_extra || ended;
    push_task.extra_kind = ended ? dzep_pkg::KIND_EVENT_END : extra_kind;
    push_task.chan       = cur_ch;
    push_task.data       = s_tdata;
    push_task.tbase      = time_counter;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= dzep_pkg::PH_HEADER;
      hdr_left     <= '0;
      mask         <= '0;
      cur_ch       <= '0;
      ewc          <= '0;
      budget       <= '0;
      counted      <= '0;
      good_left    <= '0;
      time_counter <= '0;
    end else if (accept) begin
      phase        <= phase_next;
      hdr_left     <= hdr_left_next;
      mask         <= mask_next;
      cur_ch       <= cur_ch_next;
      ewc          <= ewc_next;
      budget       <= budget_next;
      counted      <= counted_next;
      good_left    <= good_left_next;
      time_counter <= time_counter_next;
    end
  end

  a_raw_budget: assert property (@(posedge clk) disable iff (rst)
    phase == dzep_pkg::PH_RAW |-> budget != '0)
    else $error("raw channel entered with empty budget");

  a_pair_phase: assert property (@(posedge clk) disable iff (rst)
    push && push_task.has_pair |->
      (phase == dzep_pkg::PH_ZGOOD || phase == dzep_pkg::PH_RAW))
    else $error("sample pair queued outside a data phase");

  a_skip_phase: assert property (@(posedge clk) disable iff (rst)
    push && push_task.extra_kind == dzep_pkg::KIND_BAD_SKIP |->
      phase == dzep_pkg::PH_ZCTRL)
    else $error("skip word error outside control phase");

endmodule

### sv/dzep_queue.sv
// ---------------------------------------------------------------------------
// dzep_queue
// Short job queue between the parser and the result sequencer.
// ---------------------------------------------------------------------------
module dzep_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  dzep_pkg::task_t push_task,
  output logic            full,
  input  logic            pop,
  output logic            head_valid,
  output dzep_pkg::task_t head
);

  dzep_pkg::task_t             mem [dzep_pkg::Q_DEPTH];
  logic [dzep_pkg::Q_AW-1:0]   wr_ptr;
  logic [dzep_pkg::Q_AW-1:0]   rd_ptr;
  logic [dzep_pkg::Q_CW-1:0]   count;

  assign full       = (count == dzep_pkg::Q_CW'(dzep_pkg::Q_DEPTH));
  assign head_valid = (count != '0);
  assign head       = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_task;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !full || pop)
    else $error("job queue overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> head_valid)
    else $error("job queue underflow");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= dzep_pkg::Q_CW'(dzep_pkg::Q_DEPTH))
    else $error("job queue count out of range");

endmodule

### sv/dzep_back.sv
// ---------------------------------------------------------------------------
// dzep_back
// Result sequencer: expands one job into up to three results.
// ---------------------------------------------------------------------------
module dzep_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            head_valid,
  input  dzep_pkg::task_t head,
  output logic            pop,
  output logic            m_tvalid,
  input  logic            m_tready,
  output logic [55:0]     m_tdata,
  output logic [1:0]      m_tuser,
  output logic            m_tlast
);

  logic [1:0]                step;
  logic                      load;
  logic                      is_last;
  dzep_pkg::kind_t           res_kind;
  logic [dzep_pkg::CH_W-1:0] res_chan;
  logic [15:0]               res_value;
  logic [31:0]               res_time;

  dzep_pkg::kind_t           out_kind;
  logic [dzep_pkg::CH_W-1:0] out_chan;
  logic [15:0]               out_value;
  logic [31:0]               out_time;

  assign load = head_valid && (!m_tvalid || m_tready);
  assign pop  = load && is_last;

  always_comb begin
    res_kind  = head.extra_kind;
    res_chan  = '0;
    res_value = '0;
    res_time  = '0;
    if (head.has_pair && step == 2'd0) begin
      res_kind  = dzep_pkg::KIND_SAMPLE;
      res_chan  = head.chan;
      res_value = head.data[15:0];
      res_time  = head.tbase;
    end else if (head.has_pair && step == 2'd1) begin
      res_kind  = dzep_pkg::KIND_SAMPLE;
      res_chan  = head.chan;
      res_value = head.data[31:16];
      res_time  = head.tbase + 32'd1;
    end else if (head.extra_kind == dzep_pkg::KIND_BAD_SKIP) begin
      res_chan = head.chan;
    end
    if (head.has_pair) begin
      is_last = head.has_extra ? (step == 2'd2) : (step == 2'd1);
    end else begin
      is_last = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step     <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (load) begin
        step     <= is_last ? 2'd0 : step + 2'd1;
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_kind  <= res_kind;
      out_chan  <= res_chan;
      out_value <= res_value;
      out_time  <= res_time;
      m_tlast   <= is_last;
    end
  end

  assign m_tdata = {5'd0, out_time, out_value, out_chan};
  assign m_tuser = out_kind;

  a_error_is_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == dzep_pkg::KIND_BAD_HEADER ||
                 m_tuser == dzep_pkg::KIND_BAD_SKIP) |-> m_tlast)
    else $error("error result not marked last");

  a_step_range: assert property (@(posedge clk) disable iff (rst)
    head_valid && step == 2'd2 |-> head.has_pair && head.has_extra)
    else $error("sequencer step past end of job");

  a_step_idle: assert property (@(posedge clk) disable iff (rst)
    !head_valid |-> step == 2'd0)
    else $error("sequencer mid-job with empty queue");

endmodule

### sv/digitizer_zle_event_parser.sv
// ---------------------------------------------------------------------------
// digitizer_zle_event_parser
// Decodes digitizer event blocks (zero-suppressed or raw) into samples.
// ---------------------------------------------------------------------------
// one 32-bit block word per input transfer; the parser front end takes a word
// every cycle unless the four-deep job queue is full and turns it into at most
// one job, and the back end turns each job into its results on a single output
// register, one result per cycle unless m_tready is low. a data word gives two
// samples, so data words are bounded by that one-result-per-cycle output. a
// data word that closes the event gives three results. results are samples,
// an event-end mark, a bad-header error and an all-ones skip word error, with
// tlast on the final result of a word. the zero-suppression register is
// sampled when a channel starts.
module digitizer_zle_event_parser (
  input  logic        clk,
  input  logic        rst,
  // block word input
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [31:0] block_word
  // result output
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [55:0] m_tdata,   // [2:0] channel, [18:3] sample_value, [50:19] time_index
  output logic [1:0]  m_tuser,   // [1:0] kind
  output logic        m_tlast,   // last_of_run
  // configuration write
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_data   // zero_suppression_on
);

  logic            zs_on;       // zero-suppression mode register
  logic            q_full;
  logic            q_push;
  dzep_pkg::task_t q_in;
  logic            q_pop;
  logic            q_head_valid;
  dzep_pkg::task_t q_head;

  // config write always taken; cfg_ready is tied high
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      zs_on <= 1'b1;
    end else if (cfg_valid) begin
      zs_on <= cfg_data;
    end
  end

  // parser front end: header check, channel walk, control word decode
  dzep_front u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .zs_on     (zs_on),
    .q_full    (q_full),
    .push      (q_push),
    .push_task (q_in)
  );

  // decoupling queue
  dzep_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_task  (q_in),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_head_valid),
    .head       (q_head)
  );

  // result sequencer with registered output
  dzep_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (q_head_valid),
    .head       (q_head),
    .pop        (q_pop),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser),
    .m_tlast    (m_tlast)
  );

endmodule

### dv/tb.sv
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for the digitizer event parser. A short table of
// directed block words is followed by random event blocks in both data modes.
// Every accepted word runs through a bit-accurate decoder model, and each
// output transfer is checked against the oldest predicted result.
// ---------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import dzep_pkg::*;

  localparam int DRAIN_CYCLES = 32;
  localparam int RANDOM_WORDS = 210;
  localparam int N_DIR        = 31;

  // one predicted or observed result, one field per output field
  typedef struct packed {
    kind_t       kind;
    logic [2:0]  chan;
    logic [15:0] sample;
    logic [31:0] tidx;
    logic        last;
  } zle_result_t;

  // directed table: a block word, or a write of the mode register
  typedef enum logic {
    ROW_WORD,
    ROW_CFG
  } row_op_t;

  typedef struct packed {
    row_op_t     op;
    logic [31:0] word;
    logic        typed;   // expected result typed in below, not predicted
    kind_t       tkind;
    logic [2:0]  tchan;
  } stim_row_t;

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        s_tvalid  = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata   = 32'd0;
  logic        m_tvalid;
  logic        m_tready  = 1'b0;
  logic [55:0] m_tdata;
  logic [1:0]  m_tuser;
  logic        m_tlast;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_data  = 1'b0;

  digitizer_zle_event_parser DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),    // [31:0] block_word
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),    // [2:0] channel, [18:3] sample_value, [50:19] time_index
    .m_tuser  (m_tuser),    // [1:0] kind
    .m_tlast  (m_tlast),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)    // zero_suppression_on
  );

  always #6 clk = ~clk;

  // -------------------------------------------------------------------------
  // decoder model state, a private copy kept in step with accepted words
  // -------------------------------------------------------------------------
  logic        zsup_cfg = 1'b1;   // mode register as the block holds it
  phase_t      ph       = PH_HEADER;
  logic [1:0]  hdr_left = '0;
  logic [7:0]  ch_mask  = '0;
  logic [3:0]  cur_ch   = '0;
  logic [27:0] ev_size  = '0;
  logic [31:0] budget   = '0;
  logic [31:0] counted  = '0;
  logic [27:0] good_left = '0;
  logic [31:0] tcount   = '0;

  zle_result_t word_results[$];      // results of the word just decoded
  zle_result_t pending_results[$];   // results still owed by the block

  int  mismatches = 0;
  int  words_sent = 0;
  bit  no_idle    = 1'b0;            // shared by both sides for burst stretches

  stim_row_t dir_rows [N_DIR];

  function automatic void note_result(input kind_t k, input logic [2:0] ch,
                                      input logic [15:0] v, input logic [31:0] t);
    word_results.push_back(zle_result_t'{k, ch, v, t, 1'b0});
  endfunction

  // find the next enabled channel from first on, in raw mode a non-empty one; 1 when the event ends
  function automatic bit open_channel(input int first);
    for (int c = first; c < NUM_CHANNELS; c++) begin
      if (!ch_mask[c]) continue;
      cur_ch = 4'(c);
      tcount = '0;
      if (zsup_cfg) begin
        ph = PH_ZSIZE;
        return 1'b0;
      end
      budget  = (ev_size >= RAW_HDR_WC) ? 32'((ev_size - RAW_HDR_WC) >> 3) : 32'd0;
      counted = '0;
      if (budget != 0) begin
        ph = PH_RAW;
        return 1'b0;
      end
    end
    ph = PH_HEADER;
    return 1'b1;
  endfunction

  // after a zero-suppressed item: next control word, or close the channel
  function automatic bit zle_advance();
    if (counted <= budget) begin
      ph = PH_ZCTRL;
      return 1'b0;
    end
    return open_channel(int'(cur_ch) + 1);
  endfunction

  function automatic void decode_word(input logic [31:0] w);
    bit          ended;
    zle_result_t r;
    ended = 1'b0;
    word_results.delete();
    case (ph)
      PH_HEADER: begin
        if (w[31:20] == HDR_TAG) begin
          ev_size = w[27:0];
          ph      = PH_MASK;
        end else begin
          note_result(KIND_BAD_HEADER, 3'd0, 16'd0, 32'd0);
        end
      end
      PH_MASK: begin
        ch_mask  = w[7:0];
        hdr_left = 2'd2;
        ph       = PH_SKIPHDR;
      end
      PH_SKIPHDR: begin
        hdr_left = hdr_left - 2'd1;
        if (hdr_left == 0) ended = open_channel(0);
      end
      PH_ZSIZE: begin
        budget  = w;
        counted = 32'd2;
        ended   = zle_advance();
      end
      PH_ZCTRL: begin
        if (w[31:28] == GOOD_TAG) begin
          good_left = w[27:0];
          counted   = counted + 32'd1;
          if (good_left == 0) ended = zle_advance();
          else ph = PH_ZGOOD;
        end else if (w == SKIP_ALL1) begin
          // broken skip word drops the rest of the event
          note_result(KIND_BAD_SKIP, cur_ch[2:0], 16'd0, 32'd0);
          ph = PH_HEADER;
        end else begin
          // skip word moves time on by 2n+1, mod 2^32
          tcount  = tcount + {w[30:0], 1'b1};
          counted = counted + 32'd1;
          ended   = zle_advance();
        end
      end
      PH_ZGOOD: begin
        note_result(KIND_SAMPLE, cur_ch[2:0], w[15:0], tcount);
        note_result(KIND_SAMPLE, cur_ch[2:0], w[31:16], tcount + 32'd1);
        tcount    = tcount + 32'd2;
        counted   = counted + 32'd1;
        good_left = good_left - 28'd1;
        if (good_left == 0) ended = zle_advance();
      end
      PH_RAW: begin
        note_result(KIND_SAMPLE, cur_ch[2:0], w[15:0], tcount);
        note_result(KIND_SAMPLE, cur_ch[2:0], w[31:16], tcount + 32'd1);
        tcount  = tcount + 32'd2;
        counted = counted + 32'd1;
        if (counted >= budget) ended = open_channel(int'(cur_ch) + 1);
      end
      default: ph = PH_HEADER;
    endcase
    if (ended) note_result(KIND_EVENT_END, 3'd0, 16'd0, 32'd0);
    if (word_results.size() != 0) begin
      r      = word_results.pop_back();
      r.last = 1'b1;
      word_results.push_back(r);
    end
  endfunction

  // -------------------------------------------------------------------------
  // input side
  // -------------------------------------------------------------------------

  // one block word transfer; a typed row replaces the predicted result
  task automatic send_word(input logic [31:0] w, input bit typed = 1'b0,
                           input kind_t tkind = KIND_SAMPLE,
                           input logic [2:0] tchan = 3'd0);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 11);
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= w;
    @(posedge clk);
    while (s_tready !== 1'b1) @(posedge clk);
    // accepted at this edge
    decode_word(w);
    if (typed) pending_results.push_back(zle_result_t'{tkind, tchan, 16'd0, 32'd0, 1'b1});
    else foreach (word_results[i]) pending_results.push_back(word_results[i]);
    words_sent++;
  endtask

  // hold the sender off until every predicted result has been seen
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // mode register write, only with the block idle
  task automatic write_zsup(input logic v);
    wait_drained();
    // words with no result may still sit in the front end
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (cfg_ready !== 1'b1) @(posedge clk);
    cfg_valid <= 1'b0;
    zsup_cfg = v;
  endtask

  // one zero-suppressed channel: size word, then skip words and good runs
  task automatic send_zle_channel(input bit abort_here);
    int          nitems;
    bit          is_run [4];
    int          run_len [4];
    logic [31:0] total;
    logic [31:0] skip;
    nitems = $urandom_range(0, 3);
    total  = 32'd2;
    for (int i = 0; i < nitems; i++) begin
      is_run[i]  = 1'($urandom_range(0, 1));
      run_len[i] = is_run[i] ? $urandom_range(0, 3) : 0;
      total      = total + 32'(1 + run_len[i]);
    end
    // size word chosen so the channel closes right after the last item, or larger when cut short
    if (abort_here) send_word(total + 32'($urandom_range(0, 100)));
    else if (nitems == 0) send_word(32'($urandom_range(0, 1)));
    else send_word(total - 32'd1);
    for (int i = 0; i < nitems; i++) begin
      if (is_run[i]) begin
        send_word({GOOD_TAG, 28'(run_len[i])});
        repeat (run_len[i]) send_word($urandom);
      end else begin
        skip = $urandom;
        while (skip[31:28] == GOOD_TAG || skip == SKIP_ALL1) skip = $urandom;
        send_word(skip);
      end
    end
    if (abort_here) send_word(SKIP_ALL1);
  endtask

  // one well-formed event block in the current mode, maybe cut short
  task automatic send_event();
    logic [19:0] size;
    logic [7:0]  chmask;
    int          raw_words;
    int          abort_ch;
    chmask    = 8'($urandom);
    abort_ch  = ($urandom_range(0, 4) == 0) ? $urandom_range(0, NUM_CHANNELS - 1) : -1;
    raw_words = $urandom_range(0, 3);
    if (zsup_cfg) begin
      size = 20'($urandom);
    end else if ($urandom_range(0, 7) == 0) begin
      // size below the four header words
      raw_words = 0;
      size      = 20'($urandom_range(0, 3));
    end else begin
      size = 20'(4 + 8 * raw_words + $urandom_range(0, 7));
    end
    send_word({HDR_TAG, size});
    send_word({24'($urandom), chmask});
    send_word($urandom);   // event counter
    send_word($urandom);   // time tag
    for (int c = 0; c < NUM_CHANNELS; c++) begin
      if (chmask[c]) begin
        if (zsup_cfg) begin
          send_zle_channel(c == abort_ch);
          if (c == abort_ch) return;
        end else begin
          repeat (raw_words) send_word($urandom);
        end
      end
    end
  endtask

  // -------------------------------------------------------------------------
  // stimulus
  // -------------------------------------------------------------------------
  initial begin : stimulus
    logic [31:0] junk;
    int          start_words;
    int          events;
    dir_rows = '{
      // bad headers, both extremes
      '{ROW_WORD, 32'h0000_0000, 1'b1, KIND_BAD_HEADER, 3'd0},
      '{ROW_WORD, 32'hFFFF_FFFF, 1'b1, KIND_BAD_HEADER, 3'd0},
      // largest size, no channel enabled: end mark on the time tag
      '{ROW_WORD, 32'hA00F_FFFF, 1'b0, KIND_SAMPLE, 3'd0},
      '{ROW_WORD, 32'hFFFF_FF00, 1'b0, KIND_SAMPLE, 3'd0},
      '{ROW_WORD, 32'h0000_0000, 1'b0, KIND_SAMPLE, 3'd0},
      '{ROW_WORD, 32'hFFFF_FFFF, 1'b1, KIND_EVENT_END, 3'd0},
      // zero-suppressed event on channels 0, 2 and 7
      '{ROW_WORD, 32'hA000_0010, 1'b0, KIND_SAMPLE, 3'd0},
      '{ROW_WORD, 32'h0000_0085, 1'b0, KIND_SAMPLE, 3'd0},
      '{ROW_WORD, 32'h0000_0001, 1'b0, KIND_SAMPLE, 3'd0},
      '{ROW_WORD, 32'h0000_0002, 1'b0, KIND_SAMPLE, 3'd0},
      '{ROW_WORD, 32'h0000_0006, 1'b0, KIND_SAMPLE, 3'd0},   // channel 0 size
      '{ROW_WORD, 32'h8000_0002, 1'b0, KIND_SAMPLE, 3'd0},   // good run of two
      '{ROW_WORD, 32'hFFFF_0000, 1'b0, KIND_SAMPLE, 3'd0},
      '{ROW_WORD, 32'h1234_5678, 1'b0, KIND_SAMPLE, 3'd0},
      '{ROW_WORD, 32'h7FFF_FFFF, 1'b0, KIND_SAMPLE, 3'd0},   // skip that wraps time
      '{ROW_WORD, 32'h8000_0000, 1'b0, KIND_SAMPLE, 3'd0},   // zero-length run
      '{ROW_WORD, 32'h0000_0001, 1'b0, KIND_SAMPLE, 3'd0},   // channel 2 empty
      '{ROW_WORD, 32'hFFFF_FFFF, 1'b0, KIND_SAMPLE, 3'd0},   // channel 7 size
      '{ROW_WORD, 32'hFFFF_FFFF, 1'b1, KIND_BAD_SKIP, 3'd7},
      // raw data, two words on channel 1, three results on the last
      '{ROW_CFG,  32'h0000_0000, 1'b0, KIND_SAMPLE, 3'd0},
      '{ROW_WORD, 32'hA000_0014, 1'b0, KIND_SAMPLE, 3'd0},
      '{ROW_WORD, 32'h0000_0002, 1'b0, KIND_SAMPLE, 3'd0},
      '{ROW_WORD, 32'h0000_0000, 1'b0, KIND_SAMPLE, 3'd0},
      '{ROW_WORD, 32'h0000_0000, 1'b0, KIND_SAMPLE, 3'd0},
      '{ROW_WORD, 32'hAAAA_5555, 1'b0, KIND_SAMPLE, 3'd0},
      '{ROW_WORD, 32'h0000_FFFF, 1'b0, KIND_SAMPLE, 3'd0},
      // raw size below four: every channel empty
      '{ROW_WORD, 32'hA000_0003, 1'b0, KIND_SAMPLE, 3'd0},
      '{ROW_WORD, 32'h0000_00FF, 1'b0, KIND_SAMPLE, 3'd0},
      '{ROW_WORD, 32'h0000_0000, 1'b0, KIND_SAMPLE, 3'd0},
      '{ROW_WORD, 32'h0000_0000, 1'b1, KIND_EVENT_END, 3'd0},
      '{ROW_CFG,  32'h0000_0001, 1'b0, KIND_SAMPLE, 3'd0}
    };
    events = 0;

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed table
    foreach (dir_rows[i]) begin
      if (dir_rows[i].op == ROW_CFG) write_zsup(dir_rows[i].word[0]);
      else send_word(dir_rows[i].word, dir_rows[i].typed, dir_rows[i].tkind,
                     dir_rows[i].tchan);
    end

    // random event blocks with some noise between them
    start_words = words_sent;
    while (words_sent < start_words + RANDOM_WORDS) begin
      no_idle = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 3) == 0) write_zsup(1'($urandom_range(0, 1)));
      if ($urandom_range(0, 3) == 0) begin
        repeat ($urandom_range(1, 3)) begin
          junk = $urandom;
          if (junk[31:20] == HDR_TAG) junk[31] = 1'b0;
          send_word(junk);
        end
      end
      send_event();
      // sender holds off once mid-run until the output side has caught up
      if (events == 3) wait_drained();
      events++;
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("digitizer_zle_event_parser: match");
    end else begin
      $display("digitizer_zle_event_parser: mismatch");
    end
    $finish;
  end

  // -------------------------------------------------------------------------
  // output side: random stalls, each transfer checked against the oldest
  // prediction
  // -------------------------------------------------------------------------
  initial begin : result_sink
    zle_result_t got;
    zle_result_t want;
    int          stall;
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 11);
      if (stall != 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (m_tvalid !== 1'b1) @(posedge clk);
      got.kind   = kind_t'(m_tuser);
      got.chan   = m_tdata[2:0];
      got.sample = m_tdata[18:3];
      got.tidx   = m_tdata[50:19];
      got.last   = m_tlast;
      if (pending_results.size() == 0) begin
        $display("%0t: result with none expected: kind %0d ch %0d sample %h time %h last %b",
                 $realtime, got.kind, got.chan, got.sample, got.tidx, got.last);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          $display("%0t: expected kind %0d ch %0d sample %h time %h last %b",
                   $realtime, want.kind, want.chan, want.sample, want.tidx, want.last);
          $display("%0t:   actual kind %0d ch %0d sample %h time %h last %b",
                   $realtime, got.kind, got.chan, got.sample, got.tidx, got.last);
          mismatches++;
        end
      end
    end
  end

  // hang guard
  initial begin : watchdog
    #2_000_000;
    $display("digitizer_zle_event_parser: mismatch");
    $finish;
  end

endmodule

### sim.f
sv/dzep_pkg.sv
sv/dzep_front.sv
sv/dzep_queue.sv
sv/dzep_back.sv
sv/digitizer_zle_event_parser.sv
dv/tb.sv
